/* design/bbr_pkg.sv */
// Shared constants and types for the RGB box blur block.
package bbr_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int MaxWindow = 15;

  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 2;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int ChanMax  = 255;

  localparam int ResetWidth  = 512;
  localparam int ResetHeight = 512;
  localparam int ResetWindow = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_WINDOW_SIZE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_SCAN,
    BK_FLUSH,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

/* design/bbr_queue.sv */
// Two-entry job queue between the front and back parts.
module bbr_queue
  import bbr_pkg::*;
#(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

/* design/bbr_front.sv */
// Front part: takes pixels, writes the line store, tracks positions, issues output jobs.
module bbr_front
  import bbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight,
  parameter int MAX_WINDOW = MaxWindow
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       height_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       size_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic [ChanW-1:0]                      red_in_i,
  input  logic [ChanW-1:0]                      green_in_i,
  input  logic [ChanW-1:0]                      blue_in_i,
  output logic                                  mem_we_o,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0] mem_waddr_o,
  output logic [PixW-1:0]                       mem_wdata_o,
  output logic                                  job_push_o,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH):0] job_o,
  input  logic                                  job_full_i,
  input  logic                                  pending_i
);

  localparam int Depth = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int SzW   = $clog2(MAX_WINDOW + 1);
  localparam int M1    = (RowW > ColW) ? RowW : ColW;
  localparam int PW    = ((M1 > SzW) ? M1 : SzW) + 1;

  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d, in_row_n;
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, in_col_n;
  logic [AW-1:0]   waddr_q, waddr_d, oaddr_q, oaddr_d, waddr_n;
  logic            rcv_q, rcv_d, rcv_n;
  logic            take, wr, ready_out, last;
  logic [ColW:0]   col_inc;
  logic [RowW:0]   row_inc;
  logic [SzW-1:0]  half;
  logic [PW-1:0]   tr, tc, tr_full, tc_full, hm1, wm1;

  assign half       = size_i >> 1;
  assign in_ready_o = !job_full_i && !(pending_i && !rcv_q &&
                      (in_row_q == '0) && (in_col_q == '0));
  assign take       = in_valid_i && in_ready_o;
  assign wr         = take && (command_i == CMD_PIXEL) && !rcv_q;

  assign mem_we_o    = wr;
  assign mem_waddr_o = waddr_q;
  assign mem_wdata_o = {blue_in_i, green_in_i, red_in_i};

  always_comb begin
    col_inc  = {1'b0, in_col_q} + 1'b1;
    row_inc  = {1'b0, in_row_q} + 1'b1;
    in_col_n = in_col_q;
    in_row_n = in_row_q;
    rcv_n    = rcv_q;
    waddr_n  = waddr_q;
    if (wr) begin
      waddr_n = (waddr_q == AW'(Depth - 1)) ? '0 : waddr_q + 1'b1;
      if (col_inc >= (ColW+1)'(width_i)) begin
        in_col_n = '0;
        if (row_inc >= (RowW+1)'(height_i)) begin
          in_row_n = '0;
          rcv_n    = 1'b1;
        end else begin
          in_row_n = row_inc[RowW-1:0];
        end
      end else begin
        in_col_n = col_inc[ColW-1:0];
      end
    end
  end

  always_comb begin
    hm1     = PW'(height_i) - 1'b1;
    wm1     = PW'(width_i) - 1'b1;
    tr_full = PW'(out_row_q) + PW'(half);
    tc_full = PW'(out_col_q) + PW'(half);
    tr      = (tr_full < hm1) ? tr_full : hm1;
    tc      = (tc_full < wm1) ? tc_full : wm1;
    ready_out = rcv_n || (PW'(in_row_n) > tr) ||
                ((PW'(in_row_n) == tr) && (PW'(in_col_n) > tc));
    last = (PW'(out_row_q) == hm1) && (PW'(out_col_q) == wm1);
  end

  assign job_push_o = take && ready_out;
  assign job_o      = {oaddr_q, out_row_q, out_col_q, last};

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    rcv_d     = rcv_q;
    waddr_d   = waddr_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    oaddr_d   = oaddr_q;
    if (restart_i) begin
      in_row_d  = '0;
      in_col_d  = '0;
      rcv_d     = 1'b0;
      waddr_d   = '0;
      out_row_d = '0;
      out_col_d = '0;
      oaddr_d   = '0;
    end else if (take) begin
      in_row_d = in_row_n;
      in_col_d = in_col_n;
      rcv_d    = rcv_n;
      waddr_d  = waddr_n;
      if (job_push_o) begin
        if (last) begin
          in_row_d  = '0;
          in_col_d  = '0;
          rcv_d     = 1'b0;
          waddr_d   = '0;
          out_row_d = '0;
          out_col_d = '0;
          oaddr_d   = '0;
        end else begin
          oaddr_d = (oaddr_q == AW'(Depth - 1)) ? '0 : oaddr_q + 1'b1;
          if (PW'(out_col_q) == wm1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      rcv_q     <= 1'b0;
      waddr_q   <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      oaddr_q   <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      rcv_q     <= rcv_d;
      waddr_q   <= waddr_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      oaddr_q   <= oaddr_d;
    end
  end

endmodule

/* design/bbr_back.sv */
// Back part: line store, window scan and sum, divide, saturate, output register.
module bbr_back
  import bbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight,
  parameter int MAX_WINDOW = MaxWindow
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       height_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       size_i,
  input  logic                                  mem_we_i,
  input  logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0] mem_waddr_i,
  input  logic [PixW-1:0]                       mem_wdata_i,
  input  logic                                  job_valid_i,
  input  logic [$clog2(MAX_WINDOW*MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH):0] job_i,
  output logic                                  job_pop_o,
  output logic                                  busy_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [ChanW-1:0]                      red_out_o,
  output logic [ChanW-1:0]                      green_out_o,
  output logic [ChanW-1:0]                      blue_out_o,
  output logic                                  frame_last_o
);

  localparam int Depth = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int SzW   = $clog2(MAX_WINDOW + 1);
  localparam int M1    = (RowW > ColW) ? RowW : ColW;
  localparam int PW    = ((M1 > SzW) ? M1 : SzW) + 1;
  localparam int DivW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SumW  = $clog2(MAX_WINDOW * MAX_WINDOW * ChanMax + 1);
  localparam int CntW  = $clog2(SumW + 1);

  back_state_e     state_q, state_d;
  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rd_q;
  logic            rd_vld_q, rd_vld_d;

  logic [AW-1:0]   caddr;
  logic [RowW-1:0] jrow;
  logic [ColW-1:0] jcol;
  logic            jlast;
  assign {caddr, jrow, jcol, jlast} = job_i;

  logic [AW-1:0]   row_addr_q, row_addr_d, addr_q, addr_d;
  logic [SzW-1:0]  cnt_q, cnt_d, dc_q, dc_d, ncols_q, ncols_d, nrows_q, nrows_d;
  logic [SzW-1:0]  col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [DivW-1:0] div_q, div_d;
  logic [SumW-1:0] acc_q [3];
  logic [SumW-1:0] acc_d [3];
  logic [DivW-1:0] rem_q [3];
  logic [DivW-1:0] rem_d [3];
  logic [CntW-1:0] dcnt_q, dcnt_d;
  logic            last_q, last_d;
  logic [ChanW-1:0] res_q [3];
  logic [ChanW-1:0] res_d [3];

  logic [SzW-1:0]  half, dr, dcv;
  logic [PW-1:0]   tr_full, tc_full, tr, tc, hm1, wm1;
  logic            issue_last;
  logic [AW:0]     sub_a, sub_b, sub_r, add_r;
  logic [DivW:0]   shl [3];
  logic [DivW:0]   trial [3];

  assign half = size_i >> 1;

  always_comb begin
    hm1     = PW'(height_i) - 1'b1;
    wm1     = PW'(width_i) - 1'b1;
    tr_full = PW'(jrow) + PW'(half);
    tc_full = PW'(jcol) + PW'(half);
    tr      = (tr_full < hm1) ? tr_full : hm1;
    tc      = (tc_full < wm1) ? tc_full : wm1;
    dr      = (PW'(jrow) < PW'(half)) ? SzW'(jrow) : half;
    dcv     = (PW'(jcol) < PW'(half)) ? SzW'(jcol) : half;
  end

  assign issue_last = (col_cnt_q == ncols_q) && (row_cnt_q == nrows_q);

  // modular subtract / add on the ring address
  always_comb begin
    sub_a = {1'b0, row_addr_q};
    sub_b = (cnt_q != '0) ? (AW+1)'(width_i) : (AW+1)'(dc_q);
    sub_r = sub_a - sub_b;
    if (sub_a < sub_b) sub_r = sub_r + (AW+1)'(Depth);
    if (col_cnt_q == ncols_q) add_r = {1'b0, row_addr_q} + (AW+1)'(width_i);
    else                      add_r = {1'b0, addr_q} + 1'b1;
    if (add_r >= (AW+1)'(Depth)) add_r = add_r - (AW+1)'(Depth);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (job_valid_i) state_d = BK_SETUP;
      BK_SETUP: if (cnt_q == '0) state_d = BK_SCAN;
      BK_SCAN:  if (issue_last) state_d = BK_FLUSH;
      BK_FLUSH: state_d = BK_DIV;
      BK_DIV:   if (dcnt_q == CntW'(1)) state_d = BK_OUT;
      BK_OUT:   if (out_ready_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    row_addr_d = row_addr_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    dc_d       = dc_q;
    ncols_d    = ncols_q;
    nrows_d    = nrows_q;
    col_cnt_d  = col_cnt_q;
    row_cnt_d  = row_cnt_q;
    div_d      = div_q;
    dcnt_d     = dcnt_q;
    last_d     = last_q;
    rd_vld_d   = 1'b0;
    acc_d      = acc_q;
    rem_d      = rem_q;
    res_d      = res_q;
    for (int i = 0; i < 3; i++) begin
      shl[i]   = {rem_q[i], acc_q[i][SumW-1]};
      trial[i] = shl[i] - (DivW+1)'(div_q);
    end
    if (rd_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        acc_d[i] = acc_q[i] + SumW'(rd_q[i*ChanW +: ChanW]);
      end
    end
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          row_addr_d = caddr;
          cnt_d      = dr;
          dc_d       = dcv;
          nrows_d    = SzW'(tr - PW'(jrow) + PW'(dr));
          ncols_d    = SzW'(tc - PW'(jcol) + PW'(dcv));
          col_cnt_d  = '0;
          row_cnt_d  = '0;
          div_d      = DivW'(size_i) * DivW'(size_i);
          last_d     = jlast;
          for (int i = 0; i < 3; i++) acc_d[i] = '0;
        end
      end
      BK_SETUP: begin
        row_addr_d = sub_r[AW-1:0];
        addr_d     = sub_r[AW-1:0];
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      end
      BK_SCAN: begin
        rd_vld_d = 1'b1;
        addr_d   = add_r[AW-1:0];
        if (col_cnt_q == ncols_q) begin
          row_addr_d = add_r[AW-1:0];
          col_cnt_d  = '0;
          row_cnt_d  = row_cnt_q + 1'b1;
        end else begin
          col_cnt_d = col_cnt_q + 1'b1;
        end
      end
      BK_FLUSH: begin
        dcnt_d = CntW'(SumW);
        for (int i = 0; i < 3; i++) rem_d[i] = '0;
      end
      BK_DIV: begin
        dcnt_d = dcnt_q - 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (shl[i] >= (DivW+1)'(div_q)) begin
            rem_d[i] = trial[i][DivW-1:0];
            acc_d[i] = {acc_q[i][SumW-2:0], 1'b1};
          end else begin
            rem_d[i] = shl[i][DivW-1:0];
            acc_d[i] = {acc_q[i][SumW-2:0], 1'b0};
          end
          if (dcnt_q == CntW'(1)) begin
            res_d[i] = (acc_d[i] > SumW'(ChanMax)) ? ChanW'(ChanMax) : acc_d[i][ChanW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) mem_q[mem_waddr_i] <= mem_wdata_i;
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    row_addr_q <= row_addr_d;
    addr_q     <= addr_d;
    dc_q       <= dc_d;
    ncols_q    <= ncols_d;
    nrows_q    <= nrows_d;
    div_q      <= div_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    res_q      <= res_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      dcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      cnt_q     <= cnt_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      dcnt_q    <= dcnt_d;
    end
  end

  always_comb begin
    job_pop_o    = (state_q == BK_IDLE) && job_valid_i;
    busy_o       = (state_q != BK_IDLE);
    out_valid_o  = (state_q == BK_OUT);
    red_out_o    = res_q[0];
    green_out_o  = res_q[1];
    blue_out_o   = res_q[2];
    frame_last_o = last_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (col_cnt_q <= ncols_q))
    else $error("column count ran past window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (row_cnt_q <= nrows_q))
    else $error("row count ran past window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == BK_SCAN || state_q == BK_FLUSH))
    else $error("read data outside scan");

endmodule

/* design/box_blur_rgb_clipped_window_top.sv */
// Each output: setup to the window corner, one store read per window pixel, flush, divide, output.
// One output per window scan plus divide while the receiver takes it; set by the single line store read port.
// Inputs that release no output are taken at one per cycle while the two-entry job queue has room.
// A new frame waits for the previous frame's pending outputs to finish.
// Reset clears positions and config to defaults; the line store is not cleared.
module box_blur_rgb_clipped_window_top
  import bbr_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight,
  parameter int MAX_WINDOW = MaxWindow
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChanW-1:0]    red_out_o,
  output logic [ChanW-1:0]    green_out_o,
  output logic [ChanW-1:0]    blue_out_o,
  output logic                frame_last_o
);

  localparam int AW   = $clog2(MAX_WINDOW * MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int SzW  = $clog2(MAX_WINDOW + 1);
  localparam int JobW = AW + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 1;

  logic [WW-1:0]  width_q, width_d;
  logic [HW-1:0]  height_q, height_d;
  logic [SzW-1:0] size_q, size_d;
  logic           restart;
  logic [3:0]     wsz;

  assign wsz = cfg_data_i[3:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    size_d   = size_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_data_i == '0) width_d = WW'(1);
          else if (32'(cfg_data_i) > MAX_WIDTH) width_d = WW'(MAX_WIDTH);
          else width_d = WW'(cfg_data_i);
        end
        CFG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data_i == '0) height_d = HW'(1);
          else if (32'(cfg_data_i) > MAX_HEIGHT) height_d = HW'(MAX_HEIGHT);
          else height_d = HW'(cfg_data_i);
        end
        CFG_WINDOW_SIZE: begin
          restart = 1'b1;
          if (wsz == '0) size_d = SzW'(1);
          else if (32'(wsz) > MAX_WINDOW) size_d = SzW'(MAX_WINDOW);
          else size_d = SzW'(wsz);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'((ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth);
      height_q <= HW'((ResetHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetHeight);
      size_q   <= SzW'((ResetWindow > MAX_WINDOW) ? MAX_WINDOW : ResetWindow);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      size_q   <= size_d;
    end
  end

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [PixW-1:0] mem_wdata;
  logic            push, full, pop, qvalid, busy;
  logic [JobW-1:0] job_in, job_out;

  bbr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .width_i    (width_q),
    .height_i   (height_q),
    .size_i     (size_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .job_push_o (push),
    .job_o      (job_in),
    .job_full_i (full),
    .pending_i  (qvalid || busy)
  );

  bbr_queue #(
    .DataW(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvalid),
    .data_o (job_out)
  );

  bbr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .size_i      (size_q),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .job_valid_i (qvalid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_last_o(frame_last_o)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the RGB box blur with a clipped window.
module tb_top
  import bbr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = MaxWindow * MaxWidth;
  localparam int StallLimit = 20000;
  localparam int DrainWait  = 300;

  class blur_scoreboard;
    logic [PixW-1:0] pix_ring[StoreDepth];
    int unsigned width, height, win;
    int unsigned in_r, in_c, out_r, out_c;
    bit          frame_done;
    logic [PixW:0] blur_q[$];
    int          errors;

    function new();
      width = ResetWidth;
      height = ResetHeight;
      win = ResetWindow;
      restart();
    endfunction

    function void restart();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0; frame_done = 0;
    endfunction

    function int unsigned sat_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void configure(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  width = sat_reg(32'(v), MaxWidth);
        CFG_FRAME_HEIGHT: height = sat_reg(32'(v), MaxHeight);
        CFG_WINDOW_SIZE:  win = sat_reg(32'(v[3:0]), MaxWindow);
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned outstanding();
      return frame_done ? width * height - (out_r * width + out_c) : 0;
    endfunction

    function void note_input(cmd_e cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned half, tr, tc, r0, c0, div;
      int unsigned acc[3];
      logic [PixW-1:0] px;
      logic [7:0] ch[3];
      bit last;
      half = win / 2;
      if (cmd == CMD_PIXEL && !frame_done) begin
        pix_ring[(in_r * width + in_c) % StoreDepth] = {b, g, r};
        in_c++;
        if (in_c >= width) begin
          in_c = 0;
          in_r++;
          if (in_r >= height) begin
            in_r = 0;
            frame_done = 1;
          end
        end
      end
      tr = (out_r + half < height - 1) ? out_r + half : height - 1;
      tc = (out_c + half < width - 1) ? out_c + half : width - 1;
      if (!frame_done && in_r * width + in_c <= tr * width + tc) return;
      r0 = (out_r > half) ? out_r - half : 0;
      c0 = (out_c > half) ? out_c - half : 0;
      acc = '{0, 0, 0};
      for (int unsigned rr = r0; rr <= tr; rr++)
        for (int unsigned cc = c0; cc <= tc; cc++) begin
          px = pix_ring[(rr * width + cc) % StoreDepth];
          acc[0] += px[7:0];
          acc[1] += px[15:8];
          acc[2] += px[23:16];
        end
      div = win * win;
      for (int k = 0; k < 3; k++)
        ch[k] = (acc[k] / div > ChanMax) ? 8'(ChanMax) : 8'(acc[k] / div);
      last = (out_r == height - 1) && (out_c == width - 1);
      blur_q.push_back({last, ch[2], ch[1], ch[0]});
      if (last) restart();
      else begin
        out_c++;
        if (out_c >= width) begin
          out_c = 0;
          out_r++;
        end
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
      logic [PixW:0] exp_px;
      if (blur_q.size() == 0) begin
        report("output transfer with nothing expected");
        return;
      end
      exp_px = blur_q.pop_front();
      if (r !== exp_px[7:0])
        report($sformatf("red_out %0d, expected %0d", r, exp_px[7:0]));
      if (g !== exp_px[15:8])
        report($sformatf("green_out %0d, expected %0d", g, exp_px[15:8]));
      if (b !== exp_px[23:16])
        report($sformatf("blue_out %0d, expected %0d", b, exp_px[23:16]));
      if (last !== exp_px[24])
        report($sformatf("frame_last %0b, expected %0b", last, exp_px[24]));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we, in_valid, command, out_ready;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic [7:0] red_in, green_in, blue_in;
  logic in_ready_o, out_valid_o, frame_last_o;
  logic [7:0] red_out_o, green_out_o, blue_out_o;

  blur_scoreboard sb;
  int snd_idle, rcv_idle, n_items, stall_cnt, hold_cnt;
  bit hold_req;

  box_blur_rgb_clipped_window_top i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o,
    .command_i(command), .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o, .out_ready_i(out_ready),
    .red_out_o, .green_out_o, .blue_out_o, .frame_last_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req <= 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      out_ready <= 0;
      hold_cnt--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      sb.check_result(red_out_o, green_out_o, blue_out_o, frame_last_o);
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(cmd_e cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid = 0;
      @(negedge clk_i);
    end
    in_valid = 1;
    command = cmd;
    red_in = r;
    green_in = g;
    blue_in = b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, r, g, b);
    n_items++;
    if (n_items < 320) begin
      snd_idle = 37; rcv_idle = 88;
    end else if (n_items < 640) begin
      snd_idle = 88; rcv_idle = 37;
    end else begin
      snd_idle = 0; rcv_idle = 0;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid = 0;
    while (sb.blur_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = v;
    sb.configure(idx, v);
    @(negedge clk_i);
    cfg_we = 0;
  endtask

  // pattern: 0 random, 1 all full scale, 2 all zero
  task automatic run_frames(int w, int h, int ws, int frames, int pattern);
    logic [7:0] r, g, b;
    int npix;
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(w));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(h));
    write_reg(CFG_WINDOW_SIZE, CfgDataW'(ws));
    for (int f = 0; f < frames; f++) begin
      npix = sb.width * sb.height;
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        case (pattern)
          1: begin r = 8'hff; g = 8'hff; b = 8'hff; end
          2: begin r = 8'h00; g = 8'h00; b = 8'h00; end
          default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
        endcase
        send_item(CMD_PIXEL, r, g, b);
      end
      while (sb.outstanding() != 0) begin
        if ($urandom_range(0, 4) == 0)
          send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        else send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_we = 0; cfg_idx = CFG_FRAME_WIDTH; cfg_data = '0;
    in_valid = 0; command = CMD_PIXEL;
    red_in = '0; green_in = '0; blue_in = '0;
    out_ready = 0;
    snd_idle = 37; rcv_idle = 88;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    run_frames(3, 2, 1, 1, 0);
    run_frames(3, 2, 2, 1, 1);     // even window saturates
    run_frames(2, 2, 15, 1, 1);    // window far larger than frame
    run_frames(0, 0, 0, 2, 2);     // zero writes saturate to 1
    wait_idle();
    hold_req = 1;                  // receiver holds off, input backs up
    run_frames(8, 6, 3, 1, 0);
    run_frames(1023, 1, 1023, 1, 0);
    while (n_items < 950) begin
      run_frames($urandom_range(1, 12), $urandom_range(1, 8),
                 $urandom_range(0, 15), $urandom_range(1, 2),
                 ($urandom_range(0, 7) == 0) ? 1 : 0);
    end
    wait_idle();
    if (sb.errors == 0 && sb.blur_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
